### rtl/core/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg: shared types and constants for the framed serial receiver
// Holds the byte and result payload types, the parse phase encoding, the frame
// constants and the byte-wide CRC-16/MODBUS update.
// ----------------------------------------------------------------------------
package sfr_pkg;

	// Frame constants
	localparam logic [7:0]  SYNC_BYTE   = 8'h6C;
	localparam logic [7:0]  SECOND_A    = 8'hAA;
	localparam logic [7:0]  SECOND_B    = 8'hA1;
	localparam logic [15:0] CRC_INIT    = 16'hFFFF;
	localparam logic [15:0] CRC_POLY    = 16'hA001;
	localparam logic [7:0]  MAX_PAYLOAD = 8'd16;

	// Result kinds
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_END     = 1'b1;

	// Frame status codes
	typedef enum logic [1:0] {
		ST_GOOD     = 2'd0,
		ST_CRC_BAD  = 2'd1,
		ST_TOO_LONG = 2'd2
	} status_t;

	// Parse phase of the deframer
	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_SYNC    = 3'd1,
		PH_TYPE_HI = 3'd2,
		PH_TYPE_LO = 3'd3,
		PH_LEN     = 3'd4,
		PH_PAYLOAD = 3'd5,
		PH_CRC_LO  = 3'd6
	} phase_t;

	// Input payload: one received byte
	typedef struct packed {
		logic [7:0] rx_byte;
	} rx_item_t;

	// Output payload: one result
	typedef struct packed {
		logic        result_kind;
		logic [7:0]  payload_byte;
		logic [15:0] frame_type;
		logic [7:0]  frame_length;
		logic [1:0]  frame_status;
		logic        frame_last;
	} result_t;

	// One byte into a reflected CRC-16, LSB first, eight shift steps.
	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

### rtl/core/sfr_stream_if.sv
// ----------------------------------------------------------------------------
// sfr_stream_if: valid/ready stream channel
// Carries one payload per transfer; a transfer happens on a rising edge with
// valid and ready both high.
// ----------------------------------------------------------------------------
interface sfr_stream_if #(
	parameter type data_t = logic
);
	logic  valid;
	logic  ready;
	data_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/core/serial_frame_receiver_crc16.sv
// ----------------------------------------------------------------------------
// serial_frame_receiver_crc16: byte-wise frame parser with CRC-16/MODBUS check
//
//   Channel  Dir  Payload     Meaning
//   rx       in   rx_item_t   one received serial byte per transfer
//   res      out  result_t    payload byte or end-of-frame result
//
// One byte is taken per cycle while res does not stall. A byte is registered
// on transfer, then parsed and CRC-updated byte-wide from the input register;
// its result (if any) is registered as the parse stage moves. A stall on res
// holds the result register; the input register keeps taking bytes until it
// too is full. Reset returns the parser to idle with no result.
// ----------------------------------------------------------------------------
module serial_frame_receiver_crc16 (
	input  logic         clk,
	input  logic         arst_n,
	sfr_stream_if.sink   rx,
	sfr_stream_if.source res
);
	import sfr_pkg::*;

	// Input register stage
	logic       valid_s1;
	logic [7:0] byte_s1;

	// Parser state
	phase_t      phase_q;
	logic [15:0] type_q;
	logic [7:0]  length_q;
	logic [7:0]  count_q;
	logic [15:0] crc_q;
	logic [7:0]  crc_hi_q;

	// Result register
	logic    res_valid_q;
	result_t res_data_q;

	// Next-state values
	phase_t      phase_d;
	logic [15:0] type_d;
	logic [7:0]  length_d;
	logic [7:0]  count_d;
	logic [15:0] crc_d;
	logic [7:0]  crc_hi_d;
	logic        emit;
	result_t     result;
	logic [15:0] crc_step;
	logic        out_free;
	logic        fire_s1;

	// Handshake: the parse stage moves when the result register can take a value.
	assign out_free  = !res_valid_q || res.ready;
	assign fire_s1   = valid_s1 && out_free;
	assign rx.ready  = !valid_s1 || fire_s1;
	assign res.valid = res_valid_q;
	assign res.data  = res_data_q;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.data.rx_byte;
		end
	end

	// Shared CRC update of the registered byte
	assign crc_step = crc_feed(crc_q, byte_s1);

	// Parser next state and result
	always_comb begin
		phase_d  = phase_q;
		type_d   = type_q;
		length_d = length_q;
		count_d  = count_q;
		crc_d    = crc_q;
		crc_hi_d = crc_hi_q;
		emit     = 1'b0;
		result   = '{result_kind: KIND_PAYLOAD, payload_byte: 8'h00, frame_type: type_q,
			frame_length: length_q, frame_status: ST_GOOD, frame_last: 1'b0};
		unique case (phase_q)
			PH_IDLE: begin
				if (byte_s1 == SYNC_BYTE) begin
					crc_d   = crc_feed(CRC_INIT, SYNC_BYTE);
					phase_d = PH_SYNC;
				end
			end
			PH_SYNC: begin
				// The header always counts as the first second-byte code.
				if (byte_s1 == SECOND_A || byte_s1 == SECOND_B) begin
					crc_d   = crc_feed(crc_q, SECOND_A);
					phase_d = PH_TYPE_HI;
				end
			end
			PH_TYPE_HI: begin
				type_d  = {byte_s1, 8'h00};
				crc_d   = crc_step;
				phase_d = PH_TYPE_LO;
			end
			PH_TYPE_LO: begin
				type_d  = {type_q[15:8], byte_s1};
				crc_d   = crc_step;
				phase_d = PH_LEN;
			end
			PH_LEN: begin
				length_d = byte_s1;
				crc_d    = crc_step;
				count_d  = 8'd0;
				if (byte_s1 > MAX_PAYLOAD) begin
					emit                = 1'b1;
					result.result_kind  = KIND_END;
					result.frame_length = byte_s1;
					result.frame_status = ST_TOO_LONG;
					result.frame_last   = 1'b1;
					phase_d             = PH_IDLE;
					crc_d               = CRC_INIT;
				end else begin
					phase_d = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				if (count_q != length_q) begin
					crc_d               = crc_step;
					count_d             = count_q + 8'd1;
					emit                = 1'b1;
					result.payload_byte = byte_s1;
				end else begin
					crc_hi_d = byte_s1;
					phase_d  = PH_CRC_LO;
				end
			end
			PH_CRC_LO: begin
				emit                = 1'b1;
				result.result_kind  = KIND_END;
				result.frame_status = ({crc_hi_q, byte_s1} == crc_q) ? ST_GOOD : ST_CRC_BAD;
				result.frame_last   = 1'b1;
				phase_d             = PH_IDLE;
				count_d             = 8'd0;
				crc_d               = CRC_INIT;
			end
			default: begin
				// Unused phase code: back to idle without a result.
				phase_d = PH_IDLE;
				count_d = 8'd0;
				crc_d   = CRC_INIT;
			end
		endcase
	end

	// Parser state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			type_q   <= 16'h0000;
			length_q <= 8'h00;
			count_q  <= 8'h00;
			crc_q    <= CRC_INIT;
			crc_hi_q <= 8'h00;
		end else if (fire_s1) begin
			phase_q  <= phase_d;
			type_q   <= type_d;
			length_q <= length_d;
			count_q  <= count_d;
			crc_q    <= crc_d;
			crc_hi_q <= crc_hi_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= fire_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && emit) begin
			res_data_q <= result;
		end
	end

endmodule

### bench/tb_serial_frame_receiver_crc16.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_serial_frame_receiver_crc16: self-checking bench for the frame receiver
// Feeds received bytes through the rx channel and mirrors the deframer in a
// local prediction model: sync and second-byte search, type and length
// capture, payload pass-through and the CRC-16/MODBUS check. Every result
// transfer is compared field by field with the oldest predicted result.
// Directed frames cover the corner cases; random traffic follows. Both sides
// of the bench idle at random.
// ----------------------------------------------------------------------------
module tb_serial_frame_receiver_crc16;
	import sfr_pkg::*;

	localparam int CLK_HALF      = 4;
	localparam int RESET_CYCLES  = 6;
	localparam int RANDOM_ITEMS  = 870;
	localparam int DRAIN_CYCLES  = 16;
	localparam int LIMIT_CYCLES  = 200000;

	logic clk;
	logic arst_n;
	int   cycles = 0;
	int   mismatches;
	int   counted_bytes;

	// Idle bounds per side; changed at random during the random traffic.
	int src_gap_max;
	int sink_stall_max;

	sfr_stream_if #(.data_t(rx_item_t)) rx_if ();
	sfr_stream_if #(.data_t(result_t))  res_if ();

	serial_frame_receiver_crc16 u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_if),
		.res    (res_if)
	);

	// Prediction state of the deframer.
	phase_t      pred_phase;
	logic [15:0] pred_type;
	logic [7:0]  pred_length;
	logic [7:0]  pred_count;
	logic [15:0] pred_crc;
	logic [7:0]  pred_crc_hi;
	result_t     expected_results[$];

	initial begin
		clk = 1'b0;
	end

	always #(CLK_HALF) clk = ~clk;

	// Cycle counter with a run limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT_CYCLES) begin
			$display("%0t: timeout after %0d cycles", $time, cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// One byte into a reflected CRC-16 with polynomial 0xA001, LSB first.
	function automatic logic [15:0] crc16_modbus_byte(input logic [15:0] crc,
		input logic [7:0] b);
		logic [15:0] r;
		r = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		end
		return r;
	endfunction

	function automatic void restart_search();
		pred_phase = PH_IDLE;
		pred_count = 8'd0;
		pred_crc   = CRC_INIT;
	endfunction

	function automatic void push_result(input logic kind, input logic [7:0] b,
		input status_t status);
		result_t r;
		r.result_kind  = kind;
		r.payload_byte = b;
		r.frame_type   = pred_type;
		r.frame_length = pred_length;
		r.frame_status = status;
		r.frame_last   = kind;
		expected_results.push_back(r);
	endfunction

	// Advances the deframer model by one byte. Returns 0 when the byte is
	// ignored (noise while idle, or a wrong second byte).
	function automatic bit deframe_byte(input logic [7:0] b);
		bit      consumed;
		status_t status;
		consumed = 1'b1;
		case (pred_phase)
			PH_IDLE: begin
				if (b == SYNC_BYTE) begin
					pred_crc   = crc16_modbus_byte(CRC_INIT, SYNC_BYTE);
					pred_phase = PH_SYNC;
				end else begin
					consumed = 1'b0;
				end
			end
			PH_SYNC: begin
				// The header always counts as the first second-byte value.
				if (b == SECOND_A || b == SECOND_B) begin
					pred_crc   = crc16_modbus_byte(pred_crc, SECOND_A);
					pred_phase = PH_TYPE_HI;
				end else begin
					consumed = 1'b0;
				end
			end
			PH_TYPE_HI: begin
				pred_type  = {b, 8'h00};
				pred_crc   = crc16_modbus_byte(pred_crc, b);
				pred_phase = PH_TYPE_LO;
			end
			PH_TYPE_LO: begin
				pred_type  = pred_type | {8'h00, b};
				pred_crc   = crc16_modbus_byte(pred_crc, b);
				pred_phase = PH_LEN;
			end
			PH_LEN: begin
				pred_length = b;
				pred_crc    = crc16_modbus_byte(pred_crc, b);
				pred_count  = 8'd0;
				if (b > MAX_PAYLOAD) begin
					push_result(KIND_END, 8'h00, ST_TOO_LONG);
					restart_search();
				end else begin
					pred_phase = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				// Once the count is reached, this byte is the CRC high byte.
				if (pred_count != pred_length) begin
					pred_crc   = crc16_modbus_byte(pred_crc, b);
					pred_count = pred_count + 8'd1;
					push_result(KIND_PAYLOAD, b, ST_GOOD);
				end else begin
					pred_crc_hi = b;
					pred_phase  = PH_CRC_LO;
				end
			end
			PH_CRC_LO: begin
				status = ({pred_crc_hi, b} == pred_crc) ? ST_GOOD : ST_CRC_BAD;
				push_result(KIND_END, 8'h00, status);
				restart_search();
			end
			default: begin
				restart_search();
			end
		endcase
		return consumed;
	endfunction

	// Sends one byte: an idle gap, then valid held until the transfer.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = $urandom_range(0, src_gap_max);
		@(negedge clk);
		if (gap > 0) begin
			rx_if.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
			@(negedge clk);
		end
		rx_if.valid <= 1'b1;
		rx_if.data  <= b;
		do @(posedge clk); while (!(rx_if.valid && rx_if.ready));
		if (deframe_byte(b)) begin
			counted_bytes++;
		end
	endtask

	// Sends a complete frame with random payload. The CRC always covers the
	// header as sync plus the first second-byte value. A length above the
	// maximum stops after the length byte, since nothing more is awaited.
	task automatic send_frame(input logic [7:0] second, input logic [15:0] ftype,
		input logic [7:0] flen, input bit corrupt);
		logic [15:0] crc;
		logic [7:0]  pb;
		crc = crc16_modbus_byte(CRC_INIT, SYNC_BYTE);
		crc = crc16_modbus_byte(crc, SECOND_A);
		crc = crc16_modbus_byte(crc, ftype[15:8]);
		crc = crc16_modbus_byte(crc, ftype[7:0]);
		crc = crc16_modbus_byte(crc, flen);
		send_byte(SYNC_BYTE);
		send_byte(second);
		send_byte(ftype[15:8]);
		send_byte(ftype[7:0]);
		send_byte(flen);
		if (flen <= MAX_PAYLOAD) begin
			for (int i = 0; i < flen; i++) begin
				pb  = 8'($urandom_range(0, 255));
				crc = crc16_modbus_byte(crc, pb);
				send_byte(pb);
			end
			if (corrupt) begin
				crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
			end
			send_byte(crc[15:8]);
			send_byte(crc[7:0]);
		end
	endtask

	function automatic void check_field(input string name, input logic [15:0] exp_val,
		input logic [15:0] act_val);
		if (exp_val !== act_val) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h",
				$time, name, exp_val, act_val);
			mismatches++;
		end
	endfunction

	// Result side: random stall before each transfer, then compare the
	// transfer with the oldest prediction.
	initial begin
		int      stall;
		result_t want;
		result_t got;
		res_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = $urandom_range(0, sink_stall_max);
			repeat (stall) @(negedge clk) res_if.ready <= 1'b0;
			@(negedge clk) res_if.ready <= 1'b1;
			do @(posedge clk); while (!(res_if.valid && res_if.ready));
			got = res_if.data;
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual %0h",
					$time, got);
				mismatches++;
			end else begin
				want = expected_results.pop_front();
				check_field("result_kind", 16'(want.result_kind),
					16'(got.result_kind));
				check_field("payload_byte", 16'(want.payload_byte),
					16'(got.payload_byte));
				check_field("frame_type", want.frame_type, got.frame_type);
				check_field("frame_length", 16'(want.frame_length),
					16'(got.frame_length));
				check_field("frame_status", 16'(want.frame_status),
					16'(got.frame_status));
				check_field("frame_last", 16'(want.frame_last),
					16'(got.frame_last));
			end
		end
	end

	// Bytes other than sync are dropped while idle.
	task automatic test_idle_noise();
		send_byte(8'h00);
		send_byte(8'hFF);
	endtask

	// A repeated sync and a wrong byte while waiting for the second byte are
	// dropped; the frame then completes with a zero length and a good CRC.
	task automatic test_bad_second_byte();
		send_byte(SYNC_BYTE);
		send_byte(8'h00);
		send_frame(SECOND_A, 16'hFFFF, 8'd0, 1'b0);
	endtask

	// The alternate second byte with a corrupted CRC on a one-byte payload.
	task automatic test_crc_mismatch();
		send_frame(SECOND_B, 16'h0000, 8'd1, 1'b1);
	endtask

	// Lengths just above the maximum and at the top of the byte range.
	task automatic test_length_too_long();
		send_frame(SECOND_A, 16'h1234, MAX_PAYLOAD + 8'd1, 1'b0);
		send_frame(SECOND_B, 16'h8001, 8'hFF, 1'b0);
	endtask

	// Mostly well-formed frames with random content, mixed with line noise,
	// wrong second bytes and raw random bytes that can break framing.
	task automatic test_random_traffic();
		int          pick;
		int          n;
		logic [7:0]  second;
		logic [7:0]  flen;
		logic [7:0]  b;
		while (counted_bytes < RANDOM_ITEMS) begin
			if ($urandom_range(0, 15) == 0) begin
				pick = $urandom_range(0, 2);
				src_gap_max = (pick == 0) ? 0 : ((pick == 1) ? 2 : 11);
				pick = $urandom_range(0, 2);
				sink_stall_max = (pick == 0) ? 0 : ((pick == 1) ? 2 : 11);
			end
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				second = $urandom_range(0, 1) ? SECOND_A : SECOND_B;
				n = $urandom_range(0, 9);
				if (n < 6) begin
					flen = 8'($urandom_range(0, 4));
				end else if (n < 8) begin
					flen = 8'($urandom_range(5, MAX_PAYLOAD));
				end else if (n == 8) begin
					flen = MAX_PAYLOAD;
				end else begin
					flen = 8'($urandom_range(MAX_PAYLOAD + 1, 255));
				end
				send_frame(second, 16'($urandom_range(0, 16'hFFFF)), flen,
					$urandom_range(0, 5) == 0);
			end else if (pick < 80) begin
				// Line noise that avoids the sync byte.
				n = $urandom_range(1, 4);
				repeat (n) begin
					b = 8'($urandom_range(0, 255));
					send_byte((b == SYNC_BYTE) ? 8'h00 : b);
				end
			end else if (pick < 88) begin
				// Sync followed by wrong second bytes.
				send_byte(SYNC_BYTE);
				n = $urandom_range(1, 3);
				repeat (n) begin
					b = 8'($urandom_range(0, 255));
					send_byte((b == SECOND_A || b == SECOND_B) ? ~b : b);
				end
			end else begin
				n = $urandom_range(1, 8);
				repeat (n) send_byte(8'($urandom_range(0, 255)));
			end
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		rx_if.valid    = 1'b0;
		rx_if.data     = '0;
		mismatches     = 0;
		counted_bytes  = 0;
		src_gap_max    = 11;
		sink_stall_max = 11;
		pred_type      = 16'h0000;
		pred_length    = 8'd0;
		pred_crc_hi    = 8'd0;
		restart_search();

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_idle_noise();
		test_bad_second_byte();
		test_crc_mismatch();
		test_length_too_long();
		counted_bytes = 0;
		test_random_traffic();

		@(negedge clk);
		rx_if.valid <= 1'b0;
		while (expected_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
